[design/range_sensor_median_filter_top_defines.svh]
// ----------------------------------------------------------------------------
// Range sensor median filter: assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_SENSOR_MEDIAN_FILTER_TOP_DEFINES_SVH
`define RANGE_SENSOR_MEDIAN_FILTER_TOP_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define RSMF_ASSERT_HOLD(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsmf check failed");
// next-cycle implication
`define RSMF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsmf check failed");
`else
`define RSMF_ASSERT_HOLD(label, ante, cons)
`define RSMF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[design/rsmf_pkg.sv]
// ----------------------------------------------------------------------------
// rsmf_pkg
// Shared widths, register indexes, reset values, beat types and helpers.
// ----------------------------------------------------------------------------
package rsmf_pkg;

  localparam int DATA_W      = 16;
  localparam int TIME_W      = 32;
  localparam int CHAN_W      = 2;
  localparam int REG_IDX_W   = 3;
  localparam int NUM_LIMITS  = 4;
  localparam int HIST_DEPTH  = 3;
  localparam int CHANNELS_DEF = 4;

  localparam logic CMD_POLL    = 1'b0;
  localparam logic CMD_BRINGUP = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_LIMIT_CH0     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT_CH3     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FRESH_WINDOW  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_TIMEOUT = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_INVALID_CODE  = 3'd6;

  localparam logic [DATA_W-1:0] LIMIT_CH0_RST     = 16'd150;
  localparam logic [DATA_W-1:0] LIMIT_CH1_RST     = 16'd600;
  localparam logic [DATA_W-1:0] LIMIT_CH2_RST     = 16'd600;
  localparam logic [DATA_W-1:0] LIMIT_CH3_RST     = 16'd150;
  localparam logic [DATA_W-1:0] FRESH_WINDOW_RST  = 16'd150;
  localparam logic [DATA_W-1:0] FRAME_TIMEOUT_RST = 16'd250;
  localparam logic [DATA_W-1:0] INVALID_CODE_RST  = 16'd65535;

  typedef struct packed {
    logic              cmd;
    logic [CHAN_W-1:0] channel;
    logic [TIME_W-1:0] now_ms;
    logic              bus_ok;
    logic              frame_ready;
    logic              range_valid;
    logic [DATA_W-1:0] raw_mm;
  } item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] channel_out;
    logic [DATA_W-1:0] distance_mm;
    logic              distance_fresh;
    logic              connected;
  } result_t;

  typedef struct packed {
    logic [NUM_LIMITS-1:0][DATA_W-1:0] limit;
    logic [DATA_W-1:0]                 fresh_window;
    logic [DATA_W-1:0]                 frame_timeout;
    logic [DATA_W-1:0]                 invalid_code;
  } cfg_t;

  // wrapping elapsed-time test
  function automatic logic passed(input logic [TIME_W-1:0] now,
                                  input logic [TIME_W-1:0] then_ms,
                                  input logic [DATA_W-1:0] interval);
    logic [TIME_W-1:0] diff;
    diff = now - then_ms;
    return diff >= {{(TIME_W-DATA_W){1'b0}}, interval};
  endfunction

  function automatic logic [DATA_W-1:0] mid3(input logic [DATA_W-1:0] a,
                                             input logic [DATA_W-1:0] b,
                                             input logic [DATA_W-1:0] c);
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return y;
  endfunction

endpackage

[design/range_sensor_median_filter_top.sv]
// ----------------------------------------------------------------------------
// range_sensor_median_filter_top
// Per-channel range conditioning with median-of-three filtering.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | cmd, channel, now_ms, status, raw_mm
//   out_    | output    | out_valid/out_stall| channel_out, distance_mm, fresh, connected
//   cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One beat accepted per cycle unless stalled; beats pass the input, then the output register.
// The rate is set by the per-channel state read-modify-write.
// Reset is synchronous; all channels come up retired with reset register values.
// A stalled result holds in the output register while one more beat waits in
// the input register; the input stalls only when both are full.
// ----------------------------------------------------------------------------
`include "range_sensor_median_filter_top_defines.svh"

module range_sensor_median_filter_top #(
  parameter int CHANNELS = rsmf_pkg::CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [rsmf_pkg::CHAN_W-1:0]        in_channel,
  input  logic [rsmf_pkg::TIME_W-1:0]        in_now_ms,
  input  logic                               in_bus_ok,
  input  logic                               in_frame_ready,
  input  logic                               in_range_valid,
  input  logic [rsmf_pkg::DATA_W-1:0]        in_raw_mm,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rsmf_pkg::CHAN_W-1:0]        out_channel_out,
  output logic [rsmf_pkg::DATA_W-1:0]        out_distance_mm,
  output logic                               out_distance_fresh,
  output logic                               out_connected,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rsmf_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [rsmf_pkg::DATA_W-1:0]        cfg_data
);

  rsmf_pkg::cfg_t    cfg_r;
  rsmf_pkg::item_t   item_r;
  rsmf_pkg::result_t res;
  rsmf_pkg::result_t res_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              advance;
  logic              in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.limit[0]      <= rsmf_pkg::LIMIT_CH0_RST;
      cfg_r.limit[1]      <= rsmf_pkg::LIMIT_CH1_RST;
      cfg_r.limit[2]      <= rsmf_pkg::LIMIT_CH2_RST;
      cfg_r.limit[3]      <= rsmf_pkg::LIMIT_CH3_RST;
      cfg_r.fresh_window  <= rsmf_pkg::FRESH_WINDOW_RST;
      cfg_r.frame_timeout <= rsmf_pkg::FRAME_TIMEOUT_RST;
      cfg_r.invalid_code  <= rsmf_pkg::INVALID_CODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        [rsmf_pkg::REG_LIMIT_CH0:rsmf_pkg::REG_LIMIT_CH3]: begin
          cfg_r.limit[cfg_index[1:0]] <= cfg_data;
        end
        rsmf_pkg::REG_FRESH_WINDOW:  cfg_r.fresh_window  <= cfg_data;
        rsmf_pkg::REG_FRAME_TIMEOUT: cfg_r.frame_timeout <= cfg_data;
        rsmf_pkg::REG_INVALID_CODE:  cfg_r.invalid_code  <= cfg_data;
        default: ;
      endcase
    end
  end

  // advance the held beat when the output register is free or draining
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !advance);
  assign out_valid_nxt = advance || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.cmd         <= in_cmd;
      item_r.channel     <= in_channel;
      item_r.now_ms      <= in_now_ms;
      item_r.bus_ok      <= in_bus_ok;
      item_r.frame_ready <= in_frame_ready;
      item_r.range_valid <= in_range_valid;
      item_r.raw_mm      <= in_raw_mm;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  rsmf_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_chan_state (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid          = out_valid_r;
  assign out_channel_out    = res_r.channel_out;
  assign out_distance_mm    = res_r.distance_mm;
  assign out_distance_fresh = res_r.distance_fresh;
  assign out_connected      = res_r.connected;

  `RSMF_ASSERT_HOLD(a_stall_only_when_full, in_stall, s1_valid_r && out_valid_r && out_stall)
  `RSMF_ASSERT_NEXT(a_advance_fills_output, advance, out_valid)
  `RSMF_ASSERT_HOLD(a_stale_reports_code,
                    out_valid && !out_distance_fresh, out_distance_mm == cfg_r.invalid_code)

endmodule

[design/rsmf_chan_state.sv]
// ----------------------------------------------------------------------------
// rsmf_chan_state
// Per-channel state, one-pass update and median-of-three result.
// ----------------------------------------------------------------------------
module rsmf_chan_state #(
  parameter int CHANNELS = rsmf_pkg::CHANNELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  rsmf_pkg::item_t   item,
  input  rsmf_pkg::cfg_t    cfg,
  output rsmf_pkg::result_t res
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [rsmf_pkg::CHAN_W:0] CH_CNT = (rsmf_pkg::CHAN_W + 1)'(CHANNELS);

  logic                                 running_r    [CHANNELS];
  logic                                 seeded_r     [CHANNELS];
  logic [1:0]                           write_slot_r [CHANNELS];
  logic [2:0][rsmf_pkg::DATA_W-1:0]     hist_r       [CHANNELS];
  logic [rsmf_pkg::DATA_W-1:0]          filt_r       [CHANNELS];
  logic [rsmf_pkg::TIME_W-1:0]          lv_time_r    [CHANNELS];
  logic [rsmf_pkg::TIME_W-1:0]          lf_time_r    [CHANNELS];

  logic                             in_range;
  logic [CH_W-1:0]                  idx;
  logic                             run_nxt;
  logic                             seed_nxt;
  logic [1:0]                       slot_nxt;
  logic [2:0][rsmf_pkg::DATA_W-1:0] hist_nxt;
  logic [rsmf_pkg::DATA_W-1:0]      filt_nxt;
  logic [rsmf_pkg::TIME_W-1:0]      lv_nxt;
  logic [rsmf_pkg::TIME_W-1:0]      lf_nxt;
  logic                             stale;
  logic                             seed_eff;
  logic [1:0]                       slot_eff;
  logic [rsmf_pkg::DATA_W-1:0]      lim;
  logic [rsmf_pkg::DATA_W-1:0]      clamped;
  logic                             fresh;

  assign in_range = {1'b0, item.channel} < CH_CNT;
  assign idx      = item.channel[CH_W-1:0];
  assign lim      = cfg.limit[item.channel];
  assign clamped  = (item.raw_mm < lim) ? item.raw_mm : lim;

  always_comb begin
    run_nxt  = running_r[idx];
    seed_nxt = seeded_r[idx];
    slot_nxt = write_slot_r[idx];
    hist_nxt = hist_r[idx];
    filt_nxt = filt_r[idx];
    lv_nxt   = lv_time_r[idx];
    lf_nxt   = lf_time_r[idx];
    stale    = rsmf_pkg::passed(item.now_ms, lv_time_r[idx], cfg.fresh_window);
    seed_eff = seeded_r[idx] && !stale;
    slot_eff = stale ? 2'd0 : write_slot_r[idx];
    if (slot_eff > 2'd2) begin
      slot_eff = 2'd0;
    end
    if (item.cmd == rsmf_pkg::CMD_BRINGUP) begin
      run_nxt = 1'b1;
      lf_nxt  = item.now_ms;
    end else if (running_r[idx]) begin
      if (!item.bus_ok ||
          (!item.frame_ready &&
           rsmf_pkg::passed(item.now_ms, lf_time_r[idx], cfg.frame_timeout))) begin
        run_nxt  = 1'b0;
        seed_nxt = 1'b0;
        slot_nxt = 2'd0;
      end else if (item.frame_ready) begin
        lf_nxt = item.now_ms;
        if (item.range_valid) begin
          if (!seed_eff) begin
            hist_nxt = {3{clamped}};
          end
          hist_nxt[slot_eff] = clamped;
          slot_nxt = (slot_eff == 2'd2) ? 2'd0 : slot_eff + 2'd1;
          seed_nxt = 1'b1;
          filt_nxt = rsmf_pkg::mid3(hist_nxt[0], hist_nxt[1], hist_nxt[2]);
          lv_nxt   = item.now_ms;
        end
      end
    end
    fresh = in_range && run_nxt && seed_nxt &&
            !rsmf_pkg::passed(item.now_ms, lv_nxt, cfg.fresh_window);
    res.channel_out    = item.channel;
    res.distance_fresh = fresh;
    res.distance_mm    = fresh ? filt_nxt : cfg.invalid_code;
    res.connected      = in_range && run_nxt &&
                         !rsmf_pkg::passed(item.now_ms, lf_nxt, cfg.frame_timeout);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        running_r[c]    <= 1'b0;
        seeded_r[c]     <= 1'b0;
        write_slot_r[c] <= 2'd0;
        lv_time_r[c]    <= '0;
        lf_time_r[c]    <= '0;
      end
    end else if (advance && in_range) begin
      running_r[idx]    <= run_nxt;
      seeded_r[idx]     <= seed_nxt;
      write_slot_r[idx] <= slot_nxt;
      lv_time_r[idx]    <= lv_nxt;
      lf_time_r[idx]    <= lf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_range) begin
      hist_r[idx] <= hist_nxt;
      filt_r[idx] <= filt_nxt;
    end
  end

endmodule
